// ----- design/mals_pkg.sv -----
// ----------------------------------------------------------------------------
// mals_pkg: shared types and constants of the moving average line sensor
// Holds the channel count, field widths, register indexes and the lane
// control group.
// ----------------------------------------------------------------------------
package mals_pkg;

    localparam int CHANNEL_COUNT  = 4;
    localparam int THRESH_BITS    = 12;
    localparam int AVG_BITS       = 12;
    localparam int BITMAP_BITS    = CHANNEL_COUNT;
    localparam int CFG_INDEX_BITS = 4;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd400;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_CH0 = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_CH1 = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_CH2 = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_CH3 = 4'd3;

    // pipeline strobes shared by all lanes
    typedef struct packed {
        logic accept;   // input request taken: write ring, update running sum
        logic advance;  // running sum moves into the divide stage
    } lane_ctrl_t;

endpackage

// ----- design/mals_lane.sv -----
// ----------------------------------------------------------------------------
// mals_lane: one channel of the moving average
// Keeps the ring of recent samples and a running sum, and divides the sum by
// the window length through a reciprocal multiply.
// ----------------------------------------------------------------------------
module mals_lane #(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 12,
    parameter int SLOT_BITS   = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mals_pkg::lane_ctrl_t   ctrl,
    input  logic [SLOT_BITS-1:0]   slot,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SAMPLE_BITS-1:0] quot
);

    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    // exact floor division for every sum below 2**SUM_BITS
    localparam int SHIFT     = SUM_BITS + $clog2(WINDOW_LEN);
    localparam int PROD_BITS = SUM_BITS + SHIFT;
    localparam logic [SHIFT-1:0] RECIP =
        SHIFT'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW_LEN];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] quot_reg;
    logic [PROD_BITS-1:0]   prod;

    // drop the overwritten sample, add the new one
    assign sum_next = sum_reg + SUM_BITS'(sample) - SUM_BITS'(ring_reg[slot]);
    assign prod     = PROD_BITS'(sum_reg) * PROD_BITS'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_LEN; k++)
            begin
                ring_reg[k] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            ring_reg[slot] <= sample;
            sum_reg        <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            quot_reg <= prod[SHIFT +: SAMPLE_BITS];
        end
    end

    assign quot = quot_reg;

endmodule

// ----- design/mals_merge.sv -----
// ----------------------------------------------------------------------------
// mals_merge: result stage
// Compares each lane's average with its threshold, packs the bitmap and
// holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module mals_merge #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   lane_valid,
    output logic                                   lane_ready,
    input  logic [SAMPLE_BITS-1:0]                 quot [mals_pkg::CHANNEL_COUNT],
    input  logic [mals_pkg::THRESH_BITS-1:0]       thresh [mals_pkg::CHANNEL_COUNT],
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mals_pkg::AVG_BITS-1:0]          avg [mals_pkg::CHANNEL_COUNT],
    output logic [mals_pkg::BITMAP_BITS-1:0]       bitmap
);

    localparam int CMP_BITS =
        (SAMPLE_BITS > mals_pkg::THRESH_BITS) ? SAMPLE_BITS : mals_pkg::THRESH_BITS;

    logic                              valid_reg;
    logic                              load;
    logic [mals_pkg::BITMAP_BITS-1:0]  bitmap_next;
    logic [mals_pkg::BITMAP_BITS-1:0]  bitmap_reg;
    logic [mals_pkg::AVG_BITS-1:0]     avg_reg [mals_pkg::CHANNEL_COUNT];

    assign lane_ready = !valid_reg || out_ready;
    assign load       = lane_valid && lane_ready;

    // channel 0 lands in the top bit
    always_comb
    begin
        for (int c = 0; c < mals_pkg::CHANNEL_COUNT; c++)
        begin
            bitmap_next[mals_pkg::CHANNEL_COUNT-1-c] =
                (CMP_BITS'(quot[c]) < CMP_BITS'(thresh[c]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int c = 0; c < mals_pkg::CHANNEL_COUNT; c++)
            begin
                avg_reg[c] <= mals_pkg::AVG_BITS'(quot[c]);
            end
            bitmap_reg <= bitmap_next;
        end
    end

    assign out_valid = valid_reg;
    assign avg       = avg_reg;
    assign bitmap    = bitmap_reg;

endmodule

// ----- design/moving_average_line_sensor_top.sv -----
// ----------------------------------------------------------------------------
// moving_average_line_sensor_top: four-channel boxcar average with line bits
// Averages the last WINDOW_LEN samples of each channel and flags channels
// whose average lies below their threshold register.
// ----------------------------------------------------------------------------
//  channel | signals                                        | role
//  in      | in_valid, in_ready, sample_ch0..3              | one sample per channel
//  out     | out_valid, out_ready, avg_ch0..3, below_bitmap | averages, below bits
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | threshold writes
//
//  one request per cycle while the output does not stall; a result is offered once its
//  request has passed the running sum register, then the reciprocal multiply into the
//  quotient register, then the compare into the result register
//  reset clears the sample rings, running sums and slot, thresholds go to 400
//  a stalled output holds the pipeline; each stage still fills while empty
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module moving_average_line_sensor_top #(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [SAMPLE_BITS-1:0]                sample_ch0,
    input  logic [SAMPLE_BITS-1:0]                sample_ch1,
    input  logic [SAMPLE_BITS-1:0]                sample_ch2,
    input  logic [SAMPLE_BITS-1:0]                sample_ch3,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mals_pkg::AVG_BITS-1:0]         avg_ch0,
    output logic [mals_pkg::AVG_BITS-1:0]         avg_ch1,
    output logic [mals_pkg::AVG_BITS-1:0]         avg_ch2,
    output logic [mals_pkg::AVG_BITS-1:0]         avg_ch3,
    output logic [mals_pkg::BITMAP_BITS-1:0]      below_bitmap,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mals_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mals_pkg::THRESH_BITS-1:0]      cfg_data
);

    localparam int SLOT_BITS = $clog2(WINDOW_LEN);
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(WINDOW_LEN - 1);

    logic [mals_pkg::THRESH_BITS-1:0] thresh_reg [mals_pkg::CHANNEL_COUNT];
    logic [SLOT_BITS-1:0]             slot_reg;
    logic                             sum_valid_reg;
    logic                             quot_valid_reg;
    logic                             quot_ready;
    logic                             merge_ready;
    logic                             accept;
    mals_pkg::lane_ctrl_t             ctrl;
    logic [SAMPLE_BITS-1:0]           sample [mals_pkg::CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0]           quot [mals_pkg::CHANNEL_COUNT];
    logic [mals_pkg::AVG_BITS-1:0]    avg [mals_pkg::CHANNEL_COUNT];

    assign sample[0] = sample_ch0;
    assign sample[1] = sample_ch1;
    assign sample[2] = sample_ch2;
    assign sample[3] = sample_ch3;

    assign quot_ready   = !quot_valid_reg || merge_ready;
    assign in_ready     = !sum_valid_reg || quot_ready;
    assign accept       = in_valid && in_ready;
    assign ctrl.accept  = accept;
    assign ctrl.advance = sum_valid_reg && quot_ready;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            sum_valid_reg  <= 1'b0;
            quot_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
            end
            if (accept)
            begin
                sum_valid_reg <= 1'b1;
            end
            else if (quot_ready)
            begin
                sum_valid_reg <= 1'b0;
            end
            if (ctrl.advance)
            begin
                quot_valid_reg <= 1'b1;
            end
            else if (merge_ready)
            begin
                quot_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < mals_pkg::CHANNEL_COUNT; c++)
            begin
                thresh_reg[c] <= mals_pkg::THRESH_RESET;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mals_pkg::REG_THRESHOLD_CH0: thresh_reg[0] <= cfg_data;
                mals_pkg::REG_THRESHOLD_CH1: thresh_reg[1] <= cfg_data;
                mals_pkg::REG_THRESHOLD_CH2: thresh_reg[2] <= cfg_data;
                mals_pkg::REG_THRESHOLD_CH3: thresh_reg[3] <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    for (genvar c = 0; c < mals_pkg::CHANNEL_COUNT; c++)
    begin : g_lane
        mals_lane #(
            .WINDOW_LEN  (WINDOW_LEN),
            .SAMPLE_BITS (SAMPLE_BITS),
            .SLOT_BITS   (SLOT_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .slot   (slot_reg),
            .sample (sample[c]),
            .quot   (quot[c])
        );
    end

    mals_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (quot_valid_reg),
        .lane_ready (merge_ready),
        .quot       (quot),
        .thresh     (thresh_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .avg        (avg),
        .bitmap     (below_bitmap)
    );

    assign avg_ch0 = avg[0];
    assign avg_ch1 = avg[1];
    assign avg_ch2 = avg[2];
    assign avg_ch3 = avg[3];

endmodule

// ----- test/moving_average_line_sensor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_line_sensor_top_tb: self-checking bench for the line sensor
// Streams four-channel sample sets through the boxcar averager with random
// idling on both handshakes. It predicts every average and line bit from its
// own copy of the sample rings and thresholds, and checks results in order
// across several threshold settings.
// ----------------------------------------------------------------------------
module moving_average_line_sensor_top_tb;

    localparam int CHANNEL_COUNT  = mals_pkg::CHANNEL_COUNT;
    localparam int THRESH_BITS    = mals_pkg::THRESH_BITS;
    localparam int AVG_BITS       = mals_pkg::AVG_BITS;
    localparam int BITMAP_BITS    = mals_pkg::BITMAP_BITS;
    localparam int CFG_INDEX_BITS = mals_pkg::CFG_INDEX_BITS;
    localparam int THRESH_RESET   = mals_pkg::THRESH_RESET;

    localparam int WINDOW_LEN    = 5;
    localparam int SAMPLE_BITS   = 12;
    localparam int PIPE_LATENCY  = 3;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int THRESH_MAX    = (1 << THRESH_BITS) - 1;
    localparam int INDEX_MAX     = (1 << CFG_INDEX_BITS) - 1;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 230;
    localparam int LONG_HOLD     = 300;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [THRESH_BITS-1:0] thresh_t;

    typedef struct packed {
        sample_t [CHANNEL_COUNT-1:0] smp;
    } sample_set_t;

    typedef struct packed {
        logic [CHANNEL_COUNT-1:0][AVG_BITS-1:0] avg;
        logic [BITMAP_BITS-1:0]                 below;
    } line_result_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        thresh_t                   data;
    } thresh_write_t;

    typedef enum int {
        RUN_RANDOM,
        RUN_NEAR_THRESH,
        RUN_LEVEL,
        RUN_EXTREME,
        RUN_LOW
    } run_kind_t;

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    sample_t                   sample_ch0 = '0;
    sample_t                   sample_ch1 = '0;
    sample_t                   sample_ch2 = '0;
    sample_t                   sample_ch3 = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic [AVG_BITS-1:0]       avg_ch0;
    logic [AVG_BITS-1:0]       avg_ch1;
    logic [AVG_BITS-1:0]       avg_ch2;
    logic [AVG_BITS-1:0]       avg_ch3;
    logic [BITMAP_BITS-1:0]    below_bitmap;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    thresh_t                   cfg_data   = '0;

    wire [CHANNEL_COUNT-1:0][AVG_BITS-1:0] avg_bus = {avg_ch3, avg_ch2, avg_ch1, avg_ch0};

    sample_set_t   sample_req_q[$];
    thresh_write_t thresh_write_q[$];
    line_result_t  avg_expect_q[$];

    // predictor state
    sample_t ring_model [CHANNEL_COUNT][WINDOW_LEN];
    int      slot_model;
    thresh_t thresh_model [CHANNEL_COUNT];

    // stimulus side view of the thresholds, used to aim samples near them
    int thresh_plan [CHANNEL_COUNT];
    int level_plan [CHANNEL_COUNT];
    int last_pick [CHANNEL_COUNT];

    int   err_cnt = 0;
    logic hold_req = 1'b0;

    int in_gap_left  = 0;
    int in_calm_left = 0;
    int stall_left   = 0;
    int out_calm     = 0;
    int hold_left    = 0;
    logic hold_done  = 1'b0;

    moving_average_line_sensor_top #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_ch0   (sample_ch0),
        .sample_ch1   (sample_ch1),
        .sample_ch2   (sample_ch2),
        .sample_ch3   (sample_ch3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .avg_ch0      (avg_ch0),
        .avg_ch1      (avg_ch1),
        .avg_ch2      (avg_ch2),
        .avg_ch3      (avg_ch3),
        .below_bitmap (below_bitmap),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 3);
        else if (r < 97)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 60);
        return n;
    endfunction

    // write the new sample into each ring, then average and compare
    task automatic predict_averages(input sample_set_t s);
        int           c;
        int           k;
        int           sum;
        line_result_t r;
        for (c = 0; c < CHANNEL_COUNT; c++)
            ring_model[c][slot_model] = s.smp[c];
        slot_model = (slot_model + 1 == WINDOW_LEN) ? 0 : slot_model + 1;
        for (c = 0; c < CHANNEL_COUNT; c++)
        begin
            sum = 0;
            for (k = 0; k < WINDOW_LEN; k++)
                sum += ring_model[c][k];
            r.avg[c] = AVG_BITS'(sum / WINDOW_LEN);
            r.below[CHANNEL_COUNT-1-c] = ((sum / WINDOW_LEN) < thresh_model[c]);
        end
        avg_expect_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // sample driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_driver
        int          gap;
        sample_set_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            sample_ch0 <= '0;
            sample_ch1 <= '0;
            sample_ch2 <= '0;
            sample_ch3 <= '0;
        end
        else if (!(in_valid && !in_ready))
        begin
            gap = in_gap_left;
            if (in_valid)
            begin
                // request just taken, pick the gap before the next one
                if (in_calm_left > 0)
                begin
                    gap = 0;
                    in_calm_left--;
                end
                else
                begin
                    gap = idle_len();
                    if ($urandom_range(0, 49) == 0)
                        in_calm_left = $urandom_range(40, 120);
                end
            end
            if (gap > 0)
            begin
                in_valid    <= 1'b0;
                in_gap_left = gap - 1;
            end
            else if (sample_req_q.size() > 0)
            begin
                nxt = sample_req_q.pop_front();
                in_valid    <= 1'b1;
                sample_ch0  <= nxt.smp[0];
                sample_ch1  <= nxt.smp[1];
                sample_ch2  <= nxt.smp[2];
                sample_ch3  <= nxt.smp[3];
                in_gap_left = 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // threshold write driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : thresh_driver
        thresh_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else if (!(cfg_valid && !cfg_ready))
        begin
            if (thresh_write_q.size() > 0)
            begin
                w = thresh_write_q.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.index;
                cfg_data  <= w.data;
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result ready, with random stalls and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_calm > 0)
                out_calm--;
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    stall_left = idle_len();
                if ($urandom_range(0, 49) == 0)
                    out_calm = $urandom_range(40, 120);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: tracks threshold writes and sample requests, checks results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        int           c;
        int           k;
        line_result_t want;
        if (!rst_n)
        begin
            for (c = 0; c < CHANNEL_COUNT; c++)
            begin
                thresh_model[c] = THRESH_RESET;
                for (k = 0; k < WINDOW_LEN; k++)
                    ring_model[c][k] = '0;
            end
            slot_model = 0;
        end
        else
        begin
            // indexes past the last channel are dropped by the block
            if (cfg_valid && cfg_ready && cfg_index < CHANNEL_COUNT)
                thresh_model[cfg_index[$clog2(CHANNEL_COUNT)-1:0]] = cfg_data;
            if (in_valid && in_ready)
                predict_averages({sample_ch3, sample_ch2, sample_ch1, sample_ch0});
            if (out_valid && out_ready)
            begin
                if (avg_expect_q.size() == 0)
                begin
                    $error("result with no request outstanding: avg %h bitmap %b",
                           avg_bus, below_bitmap);
                    err_cnt++;
                end
                else
                begin
                    want = avg_expect_q.pop_front();
                    for (c = 0; c < CHANNEL_COUNT; c++)
                        if (want.avg[c] !== avg_bus[c])
                        begin
                            $error("avg_ch%0d expected %0d actual %0d",
                                   c, want.avg[c], avg_bus[c]);
                            err_cnt++;
                        end
                    if (want.below !== below_bitmap)
                    begin
                        $error("below_bitmap expected %b actual %b", want.below, below_bitmap);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_samples(input int v0, input int v1, input int v2, input int v3);
        sample_set_t s;
        s.smp[0] = sample_t'(v0);
        s.smp[1] = sample_t'(v1);
        s.smp[2] = sample_t'(v2);
        s.smp[3] = sample_t'(v3);
        last_pick[0] = v0;
        last_pick[1] = v1;
        last_pick[2] = v2;
        last_pick[3] = v3;
        sample_req_q.push_back(s);
    endtask

    // every request answered and the pipeline empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_req_q.size() > 0 || in_valid || avg_expect_q.size() > 0);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
    endtask

    task automatic write_thresholds(input int t0, input int t1, input int t2, input int t3,
                                    input int stray_index);
        thresh_write_q.push_back(thresh_write_t'{index: mals_pkg::REG_THRESHOLD_CH0,
                                                 data: thresh_t'(t0)});
        thresh_write_q.push_back(thresh_write_t'{index: mals_pkg::REG_THRESHOLD_CH1,
                                                 data: thresh_t'(t1)});
        thresh_write_q.push_back(thresh_write_t'{index: mals_pkg::REG_THRESHOLD_CH2,
                                                 data: thresh_t'(t2)});
        thresh_write_q.push_back(thresh_write_t'{index: mals_pkg::REG_THRESHOLD_CH3,
                                                 data: thresh_t'(t3)});
        // a write to an unmapped index must leave all thresholds alone
        thresh_write_q.push_back(thresh_write_t'{index: CFG_INDEX_BITS'(stray_index),
                                   data: thresh_t'($urandom_range(0, THRESH_MAX))});
        thresh_plan[0] = t0;
        thresh_plan[1] = t1;
        thresh_plan[2] = t2;
        thresh_plan[3] = t3;
        do
            @(negedge clk);
        while (thresh_write_q.size() > 0 || cfg_valid);
    endtask

    function automatic int pick_sample(input int c, input run_kind_t kind);
        int v;
        case (kind)
            RUN_NEAR_THRESH: v = thresh_plan[c] + $urandom_range(0, 40) - 20;
            RUN_LEVEL:       v = level_plan[c] + $urandom_range(0, 6) - 3;
            RUN_EXTREME:     v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            RUN_LOW:         v = $urandom_range(0, 63);
            default:         v = $urandom_range(0, SAMPLE_MAX);
        endcase
        if ($urandom_range(0, 15) == 0)
            v = last_pick[c];
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v;
    endfunction

    initial
    begin
        int        p;
        int        c;
        int        n;
        int        run_len;
        int        t [CHANNEL_COUNT];
        run_kind_t kind [CHANNEL_COUNT];

        for (c = 0; c < CHANNEL_COUNT; c++)
        begin
            thresh_plan[c] = THRESH_RESET;
            last_pick[c]   = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rings still zero, then a warm-up ramp to full scale
        queue_samples(0, 0, 0, 0);
        repeat (5) queue_samples(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_samples('hAAA, 'h555, 'hAAA, 'h555);
        queue_samples('h555, 'hAAA, 'h555, 'hAAA);
        // averages settle on, just under and just over the reset threshold
        repeat (5) queue_samples(THRESH_RESET, THRESH_RESET - 1, THRESH_RESET + 1, 2000);
        wait_drained();

        // zero threshold on channel 0 never flags, full scale nearly always does
        write_thresholds(0, THRESH_MAX, 1, 2048, CHANNEL_COUNT);
        thresh_write_q.push_back(thresh_write_t'{index: CFG_INDEX_BITS'(INDEX_MAX),
                                   data: thresh_t'(THRESH_MAX)});
        do
            @(negedge clk);
        while (thresh_write_q.size() > 0 || cfg_valid);
        repeat (5) queue_samples(0, 0, 0, 0);
        repeat (4) queue_samples(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            for (c = 0; c < CHANNEL_COUNT; c++)
            begin
                case (p)
                    0: t[c] = THRESH_RESET;
                    1: t[c] = 0;
                    2: t[c] = THRESH_MAX;
                    4: t[c] = (c == 0) ? 0 : (c == 1) ? THRESH_MAX
                                             : $urandom_range(0, THRESH_MAX);
                    5: t[c] = $urandom_range(0, 600);
                    default: t[c] = $urandom_range(0, THRESH_MAX);
                endcase
            end
            write_thresholds(t[0], t[1], t[2], t[3],
                             $urandom_range(CHANNEL_COUNT, INDEX_MAX));

            // runs of a few windows each so the averages reach every region
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                run_len = $urandom_range(3, 20);
                for (c = 0; c < CHANNEL_COUNT; c++)
                begin
                    kind[c]       = run_kind_t'($urandom_range(0, 4));
                    level_plan[c] = $urandom_range(0, SAMPLE_MAX);
                end
                repeat (run_len)
                begin
                    queue_samples(pick_sample(0, kind[0]), pick_sample(1, kind[1]),
                                  pick_sample(2, kind[2]), pick_sample(3, kind[3]));
                    n++;
                end
            end

            // receiver backs off long enough for the block to fill and stall
            if (p == 1)
                hold_req = 1'b1;
            wait_drained();
        end

        if (err_cnt == 0 && avg_expect_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
